### hw/rtl/swd_pkg.sv
// swd_pkg: shared constants, widths and the arctangent table for the
// swerve drive wheel kinematics block. No dependencies.
`default_nettype none

package swd_pkg;

  // fixed sizes
  localparam int WHEEL_COUNT    = 4;
  localparam int CORDIC_STEPS   = 16;
  localparam int ENCODER_COUNTS = 8192;
  localparam int TABLE_LEN      = 24;
  localparam int CORDIC_ITERS   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int ITER_W         = 5;

  // datapath widths
  localparam int MUL_AW = 36;
  localparam int MUL_BW = 21;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int SUM_W  = 54;
  localparam int XY_W   = 40;
  localparam int Z_W    = 26;
  localparam int HD_W   = 17;
  localparam int SPD_W  = 22;
  localparam int DIF_W  = 40;

  // angle constants in 1/64 degree
  localparam int DEG_FULL    = 23040;
  localparam int DEG_HALF    = 11520;
  localparam int DEG_QUARTER = 5760;

  // scaled constants
  localparam int COEF_X    = 38535;
  localparam int COEF_Y    = 53019;
  localparam int INV_GAIN  = 39797;
  localparam int Z_QUARTER = 90 * 65536;

  // config register indexes
  localparam logic [2:0] REG_LIN_GAIN = 3'd0;
  localparam logic [2:0] REG_ROT_GAIN = 3'd1;
  localparam logic [2:0] REG_OFS_A    = 3'd2;
  localparam logic [2:0] REG_OFS_B    = 3'd3;
  localparam logic [2:0] REG_OFS_C    = 3'd4;
  localparam logic [2:0] REG_OFS_D    = 3'd5;

  // arctangent of 2^-i in 1/65536 degree, rounded
  function automatic logic [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] i);
    logic [Z_W-1:0] v;
    case (i)
      5'd0:  v = Z_W'(2949120);
      5'd1:  v = Z_W'(1740967);
      5'd2:  v = Z_W'(919879);
      5'd3:  v = Z_W'(466945);
      5'd4:  v = Z_W'(234379);
      5'd5:  v = Z_W'(117304);
      5'd6:  v = Z_W'(58666);
      5'd7:  v = Z_W'(29335);
      5'd8:  v = Z_W'(14668);
      5'd9:  v = Z_W'(7334);
      5'd10: v = Z_W'(3667);
      5'd11: v = Z_W'(1833);
      5'd12: v = Z_W'(917);
      5'd13: v = Z_W'(458);
      5'd14: v = Z_W'(229);
      5'd15: v = Z_W'(115);
      5'd16: v = Z_W'(57);
      5'd17: v = Z_W'(29);
      5'd18: v = Z_W'(14);
      5'd19: v = Z_W'(7);
      5'd20: v = Z_W'(4);
      5'd21: v = Z_W'(2);
      5'd22: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/swd_mul.sv
// swd_mul: shared signed multiplier with registered product.
// Depends on swd_pkg for operand widths.
`default_nettype none

module swd_mul
  import swd_pkg::*;
(
  input  wire                       clk,
  input  wire  logic signed [MUL_AW-1:0] a,
  input  wire  logic signed [MUL_BW-1:0] b,
  output logic signed [MUL_PW-1:0]  p
);

  // one product per cycle
  always_ff @(posedge clk) begin
    p <= MUL_PW'(a) * MUL_PW'(b);
  end

endmodule

`default_nettype wire

### hw/rtl/swd_cordic.sv
// swd_cordic: vectoring cordic, one rotation per cycle, with the
// half-plane pre-rotation. Depends on swd_pkg for widths and the table.
`default_nettype none

module swd_cordic
  import swd_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  input  wire  logic signed [XY_W-1:0] x_in,
  input  wire  logic signed [XY_W-1:0] y_in,
  output logic                    done,
  output logic signed [XY_W-1:0]  x_out,
  output logic signed [Z_W-1:0]   z_out
);

  logic signed [XY_W-1:0] x, y, xs, ys;
  logic signed [Z_W-1:0]  z, at;
  logic [ITER_W-1:0]      iter;
  logic                   run;

  assign xs = x >>> iter;
  assign ys = y >>> iter;
  assign at = $signed(atan_entry(iter));
  assign x_out = x;
  assign z_out = z;

  // pre-rotation on start, then micro-rotations
  always_ff @(posedge clk) begin
    if (start) begin
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x <= y_in;
          y <= -x_in;
          z <= Z_W'(Z_QUARTER);
        end else begin
          x <= -y_in;
          y <= x_in;
          z <= -Z_W'(Z_QUARTER);
        end
      end else begin
        x <= x_in;
        y <= y_in;
        z <= '0;
      end
    end else if (run) begin
      if (y > 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end
    end
  end

  // iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        iter <= '0;
      end else if (run) begin
        if (iter == ITER_W'(CORDIC_ITERS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        iter <= iter + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/swerve_drive_wheel_kinematics.sv
// swerve_drive_wheel_kinematics: top level, sequencer, config registers and
// angle wrapping. Depends on swd_pkg, swd_mul and swd_cordic.
//
//  channel  | dir | payload
//  s_axis   | in  | tdata: vel_x, vel_y, vel_rot, enc_wheel_a..d
//  m_axis   | out | tdata: wheel_index, steer_target, drive_speed; tlast
//  cfg      | in  | register index and write data
//
// One command runs the product states S_M0 to S_M6, then per wheel the sum
// state, the cordic run, the speed states S_SPD and S_SPD2, the wrap state
// (repeated until the heading lies within half a turn of the encoder
// position) and the output state; a standing wheel skips the cordic and
// speed states. The shared multiplier and the one-rotation-per-cycle cordic
// set the length of a command. s_axis_tready is high only while idle; a
// stalled result holds the sequencer. Reset loads the register defaults and
// clears the held headings.
`default_nettype none

module swerve_drive_wheel_kinematics
  import swd_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [103:0] s_axis_tdata,   // vel_x, vel_y, vel_rot, enc_wheel_a..d, zero fill
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [39:0]  m_axis_tdata,   // wheel_index, steer_target, drive_speed, zero fill
  output logic         m_axis_tlast,
  input  wire          cfg_we,
  input  wire  [2:0]   cfg_index,
  input  wire  [19:0]  cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M0   = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_M3   = 4'd4;
  localparam logic [3:0] S_M4   = 4'd5;
  localparam logic [3:0] S_M5   = 4'd6;
  localparam logic [3:0] S_M6   = 4'd7;
  localparam logic [3:0] S_SUM  = 4'd8;
  localparam logic [3:0] S_CORD = 4'd9;
  localparam logic [3:0] S_SPD  = 4'd10;
  localparam logic [3:0] S_SPD2 = 4'd11;
  localparam logic [3:0] S_WRAP = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  localparam logic signed [DIF_W-1:0] N_C     = DIF_W'(ENCODER_COUNTS);
  localparam logic signed [DIF_W-1:0] HALF_N  = DIF_W'(DEG_HALF * ENCODER_COUNTS);
  localparam logic signed [DIF_W-1:0] QUART_N = DIF_W'(DEG_QUARTER * ENCODER_COUNTS);

  logic [3:0]   state;
  logic [103:0] in_reg;
  logic [1:0]   wheel;

  // config registers
  logic [19:0]        lin_gain, rot_gain;
  logic signed [14:0] ofs [WHEEL_COUNT];
  logic signed [15:0] held [WHEEL_COUNT];

  // products
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_p;
  logic signed [MUL_AW-1:0] lin_x, lin_y, rot_p;
  logic signed [51:0]       rot_x, rot_y;

  // per-wheel datapath
  logic signed [SUM_W-1:0] sx, sy;
  logic                    cord_start, cord_done;
  logic signed [XY_W-1:0]  cord_x;
  logic signed [Z_W-1:0]   cord_z;
  logic signed [HD_W-1:0]  head;
  logic signed [SPD_W-1:0] speed;
  logic signed [SPD_W-1:0] spd_fin;
  logic signed [HD_W-1:0]  head_fin;
  logic signed [DIF_W-1:0] diff;
  logic [12:0]             pos;
  logic signed [MUL_PW-1:0] spd_round;
  logic signed [Z_W-1:0]   z_round;

  assign s_axis_tready = (state == S_IDLE);

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      lin_gain <= 20'd1006638;
      rot_gain <= 20'd17920;
      ofs[0]   <= -15'sd1920;
      ofs[1]   <= 15'sd10080;
      ofs[2]   <= -15'sd1440;
      ofs[3]   <= -15'sd1440;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIN_GAIN: lin_gain <= cfg_data;
        REG_ROT_GAIN: rot_gain <= cfg_data;
        REG_OFS_A:    ofs[0]   <= cfg_data[14:0];
        REG_OFS_B:    ofs[1]   <= cfg_data[14:0];
        REG_OFS_C:    ofs[2]   <= cfg_data[14:0];
        REG_OFS_D:    ofs[3]   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M0: begin
        mul_a = MUL_AW'($signed(in_reg[15:0]));
        mul_b = $signed({1'b0, lin_gain});
      end
      S_M1: begin
        mul_a = MUL_AW'($signed(in_reg[31:16]));
        mul_b = $signed({1'b0, lin_gain});
      end
      S_M2: begin
        mul_a = MUL_AW'($signed(in_reg[47:32]));
        mul_b = $signed({1'b0, rot_gain});
      end
      S_M4: begin
        mul_a = rot_p;
        mul_b = MUL_BW'(COEF_X);
      end
      S_M5: begin
        mul_a = rot_p;
        mul_b = MUL_BW'(COEF_Y);
      end
      S_SPD: begin
        mul_a = (cord_x < 0) ? '0 : cord_x[MUL_AW-1:0];
        mul_b = MUL_BW'(INV_GAIN);
      end
      default: ;
    endcase
  end

  swd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // wheel sums with per-wheel signs
  always_comb begin
    logic signed [SUM_W-1:0] lx, ly, rx, ry;
    lx = SUM_W'($signed({lin_x, 16'b0}));
    ly = SUM_W'($signed({lin_y, 16'b0}));
    rx = SUM_W'(rot_x);
    ry = SUM_W'(rot_y);
    sx = (wheel == 2'd0 || wheel == 2'd1) ? lx - rx : lx + rx;
    sy = (wheel == 2'd0 || wheel == 2'd3) ? ly + ry : ly - ry;
  end

  assign cord_start = (state == S_SUM) && !(sx == 0 && sy == 0);

  swd_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .x_in  (XY_W'(sy >>> 20)),
    .y_in  (XY_W'(sx >>> 20)),
    .done  (cord_done),
    .x_out (cord_x),
    .z_out (cord_z)
  );

  // encoder position of the current wheel
  always_comb begin
    case (wheel)
      2'd0:    pos = in_reg[60:48];
      2'd1:    pos = in_reg[73:61];
      2'd2:    pos = in_reg[86:74];
      default: pos = in_reg[99:87];
    endcase
  end

  // exact angle distance, scaled by the encoder count
  assign diff = DIF_W'(head) * N_C - DIF_W'(pos) * DIF_W'(DEG_FULL);

  assign spd_round = mul_p + MUL_PW'(64'sd2147483648);
  assign z_round   = cord_z + Z_W'(512);

  // final flip and saturation
  always_comb begin
    logic signed [SPD_W-1:0] s;
    head_fin = head;
    s = speed;
    if (diff > QUART_N) begin
      head_fin = head - HD_W'(DEG_HALF);
      s = -speed;
    end else if (diff < -QUART_N) begin
      head_fin = head + HD_W'(DEG_HALF);
      s = -speed;
    end
    if (s > SPD_W'(65535))       spd_fin = SPD_W'(65535);
    else if (s < -SPD_W'(65536)) spd_fin = -SPD_W'(65536);
    else                         spd_fin = s;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      wheel         <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < WHEEL_COUNT; i++) held[i] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            in_reg <= s_axis_tdata;
            wheel  <= '0;
            state  <= S_M0;
          end
        end
        S_M0: state <= S_M1;
        S_M1: begin
          lin_x <= mul_p[MUL_AW-1:0];
          state <= S_M2;
        end
        S_M2: begin
          lin_y <= mul_p[MUL_AW-1:0];
          state <= S_M3;
        end
        S_M3: begin
          rot_p <= mul_p[MUL_AW-1:0];
          state <= S_M4;
        end
        S_M4: state <= S_M5;
        S_M5: begin
          rot_x <= mul_p[51:0];
          state <= S_M6;
        end
        S_M6: begin
          rot_y <= mul_p[51:0];
          state <= S_SUM;
        end
        S_SUM: begin
          if (sx == 0 && sy == 0) begin
            head  <= HD_W'(held[wheel]);
            speed <= '0;
            state <= S_WRAP;
          end else begin
            state <= S_CORD;
          end
        end
        S_CORD: begin
          if (cord_done) state <= S_SPD;
        end
        S_SPD: state <= S_SPD2;
        S_SPD2: begin
          speed <= spd_round[SPD_W+31:32];
          head  <= HD_W'(z_round >>> 10) + HD_W'(ofs[wheel]);
          held[wheel] <= 16'(HD_W'(z_round >>> 10) + HD_W'(ofs[wheel]));
          state <= S_WRAP;
        end
        S_WRAP: begin
          if (diff > HALF_N) begin
            head <= head - HD_W'(DEG_FULL);
          end else if (diff < -HALF_N) begin
            head <= head + HD_W'(DEG_FULL);
          end else begin
            m_axis_tdata  <= {5'b0, 17'(spd_fin), 16'(head_fin), wheel};
            m_axis_tlast  <= (wheel == 2'(WHEEL_COUNT - 1));
            m_axis_tvalid <= 1'b1;
            state         <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (wheel == 2'(WHEEL_COUNT - 1)) begin
              state <= S_IDLE;
            end else begin
              wheel <= wheel + 1'b1;
              state <= S_SUM;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
